/* hw/rtl/ttl_pkg.sv */
// ----------------------------------------------------------------------------
// ttl_pkg
// Types, constants and the thermocouple table for the linearizer.
// ----------------------------------------------------------------------------
package ttl_pkg;

  localparam int FULL_TABLE = 51;
  localparam int IDX_W      = 6;
  localparam int UV_W       = 18;
  localparam int MV_W       = 29;
  localparam int OUT_W      = 20;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -20'sd10240;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sd300000;

  typedef enum logic [1:0] {
    REG_ADC_REF  = 2'd0,
    REG_ADC_RES  = 2'd1,
    REG_COLD_JCT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_FIN  = 2'd2,
    BK_OUT  = 2'd3
  } back_state_t;

  // Front-to-back queue entry: microvolts and chosen segment.
  typedef struct packed {
    logic [UV_W-1:0]  uv;
    logic [IDX_W-1:0] seg;
  } seg_item_t;

  function automatic logic [13:0] uv_point(input logic [IDX_W-1:0] i);
    logic [13:0] r;
    begin
      unique case (i)
        6'd0: r = 14'd0;      6'd1: r = 14'd266;    6'd2: r = 14'd522;
        6'd3: r = 14'd770;    6'd4: r = 14'd1010;   6'd5: r = 14'd1244;
        6'd6: r = 14'd1473;   6'd7: r = 14'd1697;   6'd8: r = 14'd1917;
        6'd9: r = 14'd2135;   6'd10: r = 14'd2351;  6'd11: r = 14'd2566;
        6'd12: r = 14'd2780;  6'd13: r = 14'd2994;  6'd14: r = 14'd3209;
        6'd15: r = 14'd3426;  6'd16: r = 14'd3644;  6'd17: r = 14'd3865;
        6'd18: r = 14'd4088;  6'd19: r = 14'd4314;  6'd20: r = 14'd4544;
        6'd21: r = 14'd4777;  6'd22: r = 14'd5014;  6'd23: r = 14'd5255;
        6'd24: r = 14'd5500;  6'd25: r = 14'd5750;  6'd26: r = 14'd6003;
        6'd27: r = 14'd6261;  6'd28: r = 14'd6523;  6'd29: r = 14'd6789;
        6'd30: r = 14'd7059;  6'd31: r = 14'd7332;  6'd32: r = 14'd7609;
        6'd33: r = 14'd7889;  6'd34: r = 14'd8171;  6'd35: r = 14'd8456;
        6'd36: r = 14'd8742;  6'd37: r = 14'd9030;  6'd38: r = 14'd9319;
        6'd39: r = 14'd9607;  6'd40: r = 14'd9896;  6'd41: r = 14'd10183;
        6'd42: r = 14'd10468; 6'd43: r = 14'd10750; 6'd44: r = 14'd11029;
        6'd45: r = 14'd11304; 6'd46: r = 14'd11573; 6'd47: r = 14'd11835;
        6'd48: r = 14'd12091; 6'd49: r = 14'd12337; 6'd50: r = 14'd12575;
        default: r = 14'd12575;
      endcase
      return r;
    end
  endfunction

endpackage

/* hw/rtl/ttl_front.sv */
// ----------------------------------------------------------------------------
// ttl_front
// Scales a code to millivolts, then to microvolts (x1000/201), and picks
// the table segment by a parallel compare against the interior points.
// ----------------------------------------------------------------------------
module ttl_front #(
  parameter int TABLE_POINTS = 51
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [15:0]                 adc_code,
  input  logic [12:0]                 vref_mv,
  input  logic [4:0]                  adc_resolution_bits,
  output logic                        q_valid,
  input  logic                        q_full,
  output ttl_pkg::seg_item_t          q_data
);
  localparam int NP = (TABLE_POINTS < 2) ? 2 :
                      ((TABLE_POINTS > ttl_pkg::FULL_TABLE) ? ttl_pkg::FULL_TABLE
                                                            : TABLE_POINTS);
  localparam int IW = ttl_pkg::IDX_W;
  localparam int UW = ttl_pkg::UV_W;
  localparam int MW = ttl_pkg::MV_W;
  // floor(x/201) for x < 2^27: multiply by ceil(2^35/201)
  localparam logic [27:0] RECIP_201 = 28'd170943972;

  // stage 1: product, stage 2: shift and x1000, stage 3: /201 and search
  logic                       v1, v2, v3;
  logic                       busy, take;
  logic [MW-1:0]              prod;
  logic [MW-1:0]              mv_c;
  logic [16:0]                mv_sat;
  logic [26:0]                mv1000;
  logic [54:0]                recip;
  logic [19:0]                uv_full;
  logic [UW-1:0]              uv;
  logic [IW-1:0]              seg;
  logic [UW-1:0]              uv_c;
  logic [IW-1:0]              seg_c;

  assign busy     = v1 | v2 | v3;
  assign in_stall = busy | rst;
  assign take     = in_valid & ~in_stall;
  assign q_valid  = v3;
  assign q_data   = '{uv: uv, seg: seg};

  // anything this large lands far past the table end and saturates anyway
  assign mv_c    = prod >> adc_resolution_bits;
  assign mv_sat  = (|mv_c[MW-1:17]) ? 17'h1FFFF : mv_c[16:0];
  assign recip   = {28'd0, mv1000} * {27'd0, RECIP_201};
  assign uv_full = recip[54:35];

  always_comb begin
    uv_c  = (|uv_full[19:UW]) ? '1 : uv_full[UW-1:0];
    seg_c = IW'(NP - 2);
    for (int i = NP - 2; i >= 1; i--) begin
      if (uv_c < {4'd0, ttl_pkg::uv_point(IW'(i))})
        seg_c = IW'(i - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      if (v2) v3 <= 1'b1;
      else if (v3 & ~q_full) v3 <= 1'b0;
    end
    if (take) prod <= {13'd0, adc_code} * {16'd0, vref_mv};
    if (v1) mv1000 <= {10'd0, mv_sat} * 27'd1000;
    if (v2) begin
      uv  <= uv_c;
      seg <= seg_c;
    end
  end
endmodule

/* hw/rtl/ttl_queue.sv */
// ----------------------------------------------------------------------------
// ttl_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module ttl_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               full,
  input  ttl_pkg::seg_item_t wr_data,
  output logic               rd_valid,
  input  logic               rd_take,
  output ttl_pkg::seg_item_t rd_data
);
  ttl_pkg::seg_item_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign full     = cnt == 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];
  assign wr       = wr_valid & ~full;
  assign rd       = rd_take & rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem[wp] <= wr_data;
  end
endmodule

/* hw/rtl/ttl_back.sv */
// ----------------------------------------------------------------------------
// ttl_back
// Interpolates within the segment, adds cold junction, saturates.
// dx is 214 to 289, so it fits the 9-bit divisor of the restoring /dx divider.
// ----------------------------------------------------------------------------
module ttl_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_take,
  input  ttl_pkg::seg_item_t          q_data,
  input  logic signed [15:0]          cold_junction_temp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [19:0]          tip_temperature
);
  localparam int NW = 27;
  localparam int IW = ttl_pkg::IDX_W;
  localparam int UW = ttl_pkg::UV_W;
  // floor(x/100) for x < 2^18: multiply by ceil(2^25/100)
  localparam logic [18:0] RECIP_100 = 19'd335545;

  ttl_pkg::back_state_t state, state_next;
  logic [4:0]          cnt;
  logic [NW-1:0]       num, quo;
  logic [8:0]          rem, dx;
  logic [9:0]          rem_sh, rem_sub;
  logic [IW-1:0]       seg;
  logic [13:0]         x1, x2, dx_full;
  logic [UW-1:0]       du;
  logic [16:0]         dc;
  logic [17:0]         qc;
  logic [36:0]         q_scaled;
  logic [11:0]         deg;
  logic signed [21:0]  tn;

  assign x1       = ttl_pkg::uv_point(q_data.seg);
  assign x2       = ttl_pkg::uv_point(q_data.seg + IW'(1));
  assign dx_full  = x2 - x1;
  // offsets this far into a segment always saturate high
  assign du       = q_data.uv - {4'd0, x1};
  assign dc       = du[UW-1] ? '1 : du[16:0];
  assign rem_sh   = {rem, num[NW-1]};
  assign rem_sub  = rem_sh - {1'b0, dx};
  assign qc       = (|quo[NW-1:18]) ? '1 : quo[17:0];
  assign q_scaled = {19'd0, qc} * {18'd0, RECIP_100};
  assign deg      = {6'd0, seg} * 12'd10 + q_scaled[36:25];
  assign tn       = $signed({2'b00, deg, 8'd0}) +
                    $signed({{6{cold_junction_temp[15]}}, cold_junction_temp});

  always_comb begin
    state_next = state;
    q_take     = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ttl_pkg::BK_IDLE: begin
        q_take = q_valid;
        if (q_valid) state_next = ttl_pkg::BK_DIV;
      end
      ttl_pkg::BK_DIV: begin
        if (cnt == 5'(NW - 1)) state_next = ttl_pkg::BK_FIN;
      end
      ttl_pkg::BK_FIN: begin
        state_next = ttl_pkg::BK_OUT;
      end
      ttl_pkg::BK_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ttl_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttl_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cnt <= '0;
      seg <= q_data.seg;
      num <= {10'd0, dc} * 27'd1000;
      dx  <= dx_full[8:0];
      rem <= '0;
      quo <= '0;
    end else if (state == ttl_pkg::BK_DIV) begin
      if (rem_sh >= {1'b0, dx}) begin
        rem <= rem_sub[8:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[8:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
      num <= num << 1;
      cnt <= cnt + 5'd1;
    end
    if (state == ttl_pkg::BK_FIN) begin
      if (tn < 22'(ttl_pkg::OUT_MIN)) tip_temperature <= ttl_pkg::OUT_MIN;
      else if (tn > 22'(ttl_pkg::OUT_MAX)) tip_temperature <= ttl_pkg::OUT_MAX;
      else tip_temperature <= tn[19:0];
    end
  end
endmodule

/* hw/rtl/thermocouple_table_linearizer_top.sv */
// ----------------------------------------------------------------------------
// thermocouple_table_linearizer_top
// ADC code to tip temperature through a piecewise-linear thermocouple table.
// ----------------------------------------------------------------------------
// Path: the front stages, the queue, then the back's bit-serial /dx divider.
// Neither the front nor the back takes a new item while it still holds one.
// Reset: synchronous; registers return to 3300 mV, 12 bits, 25 degrees.
module thermocouple_table_linearizer_top #(
  parameter int TABLE_POINTS = 51
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        adc_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] tip_temperature,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  logic [12:0]        vref_mv;
  logic [4:0]         adc_resolution_bits;
  logic signed [15:0] cold_junction_temp;
  logic               fq_valid, fq_full, bq_valid, bq_take;
  ttl_pkg::seg_item_t fq_data, bq_data;

  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vref_mv             <= 13'd3300;
      adc_resolution_bits <= 5'd12;
      cold_junction_temp  <= 16'sd6400;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ttl_pkg::REG_ADC_REF:  vref_mv             <= cfg_data[12:0];
        ttl_pkg::REG_ADC_RES:  adc_resolution_bits <= cfg_data[4:0];
        ttl_pkg::REG_COLD_JCT: cold_junction_temp  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  ttl_front #(.TABLE_POINTS(TABLE_POINTS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .adc_code, .vref_mv,
    .adc_resolution_bits, .q_valid(fq_valid), .q_full(fq_full), .q_data(fq_data)
  );

  ttl_queue u_queue (
    .clk, .rst, .wr_valid(fq_valid), .full(fq_full), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_take(bq_take), .rd_data(bq_data)
  );

  ttl_back u_back (
    .clk, .rst, .q_valid(bq_valid), .q_take(bq_take), .q_data(bq_data),
    .cold_junction_temp, .out_valid, .out_stall, .tip_temperature
  );

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tip_temperature >= ttl_pkg::OUT_MIN &&
                   tip_temperature <= ttl_pkg::OUT_MAX))
    else $error("result out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front took two items back to back");
endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermocouple linearizer testbench
// Drives ADC codes through the linearizer under several register settings,
// predicts each tip temperature with a local table model, and compares
// results in order. Random stall bursts and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NPTS     = 51;
  localparam int LIMIT    = 20000;
  localparam int N_RANDOM = 1030;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        adc_code;
  logic               out_valid;
  logic               out_stall;
  logic signed [19:0] tip_temperature;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  thermocouple_table_linearizer_top #(.TABLE_POINTS(NPTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .adc_code(adc_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .tip_temperature(tip_temperature),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  int uv_tab [NPTS] = '{
    0, 266, 522, 770, 1010, 1244, 1473, 1697, 1917, 2135,
    2351, 2566, 2780, 2994, 3209, 3426, 3644, 3865, 4088, 4314,
    4544, 4777, 5014, 5255, 5500, 5750, 6003, 6261, 6523, 6789,
    7059, 7332, 7609, 7889, 8171, 8456, 8742, 9030, 9319, 9607,
    9896, 10183, 10468, 10750, 11029, 11304, 11573, 11835, 12091, 12337,
    12575};

  logic [12:0]        ref_mv;
  logic [4:0]         res_bits;
  logic signed [15:0] cj_temp;

  logic signed [19:0] temp_q[$];
  int  mismatches;
  bit  failed;
  bit  quiet;
  bit  hold_long;
  int  idle_cycles;
  int  ostall_left;
  bit  done;

  function automatic logic signed [19:0] tip_of(logic [15:0] code);
    longint unsigned mv;
    longint uv, x1, x2, deg, t;
    int lo;
    mv = (longint'(code) * ref_mv) >> res_bits;
    uv = longint'((mv * 1000) / 201);
    lo = NPTS - 2;
    for (int i = 1; i < NPTS - 1; i++) begin
      if (uv < uv_tab[i]) begin
        lo = i - 1;
        break;
      end
    end
    x1 = uv_tab[lo];
    x2 = uv_tab[lo + 1];
    deg = lo * 10 + (((uv - x1) * 1000) / (x2 - x1)) * 10 / 1000;
    t = deg * 256 + cj_temp;
    if (t < -10240) t = -10240;
    if (t > 300000) t = 300000;
    return t[19:0];
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(ttl_pkg::reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      ttl_pkg::REG_ADC_REF:  ref_mv   = val[12:0];
      ttl_pkg::REG_ADC_RES:  res_bits = val[4:0];
      ttl_pkg::REG_COLD_JCT: cj_temp  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (temp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // one item; fix checked against the predictor when has_fix
  task automatic send(logic [15:0] code, bit has_fix, logic signed [19:0] fix);
    logic signed [19:0] p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    p = tip_of(code);
    if (has_fix && p != fix) begin
      failed = 1;
      $display("table row code %0d: typed %0d predicted %0d", code, fix, p);
    end
    in_valid <= 1;
    adc_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    temp_q.push_back(p);
  endtask

  typedef struct {
    logic [15:0]        code;
    bit                 has_fix;
    logic signed [19:0] fix;
  } row_t;

  row_t rows[] = '{
    '{16'd0,     1, 20'sd6400},
    '{16'd65535, 0, 0},
    '{16'd1,     0, 0},
    '{16'd32768, 0, 0},
    '{16'd4095,  0, 0},
    '{16'd2048,  0, 0},
    '{16'd200,   0, 0},
    '{16'd5000,  0, 0},
    '{16'd16384, 0, 0},
    '{16'd40000, 0, 0}
  };

  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 0;
      ostall_left <= 0;
    end else if (hold_long) begin
      out_stall <= 1;
    end else if (ostall_left > 0) begin
      out_stall   <= 1;
      ostall_left <= ostall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall   <= 1;
      ostall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 0;
    end
  end

  initial begin
    hold_long = 0;
    wait (done == 0);
    #2000;
    @(posedge clk);
    hold_long = 1;
    repeat (300) @(posedge clk);
    hold_long = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (temp_q.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %0d", tip_temperature);
      end else begin
        if (tip_temperature !== temp_q[0]) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("tip_temperature exp %0d got %0d", temp_q[0], tip_temperature);
        end
        void'(temp_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [15:0] code;
    rst = 1; in_valid = 0; adc_code = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    mismatches = 0; failed = 0; quiet = 0; done = 0;
    ref_mv = 3300; res_bits = 12; cj_temp = 6400;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].code, rows[i].has_fix, rows[i].fix);
    drain();
    // extremes: max reference, zero shift, lowest cold junction
    write_reg(ttl_pkg::REG_ADC_REF, 16'd8191);
    write_reg(ttl_pkg::REG_ADC_RES, 16'd0);
    write_reg(ttl_pkg::REG_COLD_JCT, 16'h8000);
    send(16'd0, 1, -20'sd10240);
    send(16'd65535, 1, 20'sd300000);
    send(16'd3, 0, 0);
    drain();
    write_reg(ttl_pkg::REG_ADC_REF, 16'd0);
    write_reg(ttl_pkg::REG_ADC_RES, 16'd31);
    write_reg(ttl_pkg::REG_COLD_JCT, 16'h7FFF);
    send(16'd65535, 1, 20'sd32767);
    send(16'd12345, 0, 0);
    drain();
    write_reg(ttl_pkg::REG_ADC_REF, 16'hE000 | 16'd5000);
    write_reg(ttl_pkg::REG_ADC_RES, 16'hFFF0);
    write_reg(ttl_pkg::REG_COLD_JCT, 16'd0);
    send(16'hAAAA, 0, 0);
    send(16'h5555, 0, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(ttl_pkg::REG_ADC_REF, 16'd3300);
          write_reg(ttl_pkg::REG_ADC_RES, 16'd12);
          write_reg(ttl_pkg::REG_COLD_JCT, 16'd6400);
        end
        1: begin
          write_reg(ttl_pkg::REG_ADC_REF, 16'd1);
          write_reg(ttl_pkg::REG_ADC_RES, 16'd8);
          write_reg(ttl_pkg::REG_COLD_JCT, -16'sd10240);
        end
        2: begin
          write_reg(ttl_pkg::REG_ADC_REF, 16'd5000);
          write_reg(ttl_pkg::REG_ADC_RES, 16'd16);
          write_reg(ttl_pkg::REG_COLD_JCT, 16'd32767);
        end
        default: begin
          write_reg(ttl_pkg::REG_ADC_REF, 16'($urandom));
          write_reg(ttl_pkg::REG_ADC_RES, 16'($urandom_range(0, 31)));
          write_reg(ttl_pkg::REG_COLD_JCT, 16'($urandom));
        end
      endcase
      if (ph == 5) quiet = 1;
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        code = 16'($urandom);
        if ($urandom_range(0, 1) == 0) code = code >> $urandom_range(0, 15);
        send(code, 0, 0);
      end
      drain();
    end
    done = 1;
    if (!failed && mismatches == 0 && temp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
